### rtl/parity_char_bit_packer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the parity character bit packer
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef PARITY_CHAR_BIT_PACKER_ASSERT_SVH
`define PARITY_CHAR_BIT_PACKER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define PCBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define PCBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCBP_ASSERT(label, prop, msg)
`define PCBP_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### rtl/pcbp_pkg.sv
// ---------------------------------------------------------------------------
// Parity character bit packer package
// Field widths shared by the interfaces and RTL, and the result item type.
// ---------------------------------------------------------------------------
package pcbp_pkg;

  localparam int CHAR_W = 9;
  localparam int BYTE_W = 8;
  localparam int OFF_W  = 3;

  // Offset at which a character fills two whole bytes.
  localparam logic [OFF_W-1:0] OFF_WRAP = 3'd7;

  // One packed result item.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_end;
    logic              frame_end;
  } res_t;

endpackage

### rtl/pcbp_if.sv
// ---------------------------------------------------------------------------
// Parity character bit packer channels
// Valid/ready channels for input characters and packed output bytes.
// ---------------------------------------------------------------------------

// Input channel: one nine-bit character per item.
interface pcbp_in_if;
  logic                        valid;
  logic                        ready;
  logic [pcbp_pkg::CHAR_W-1:0] char_value;
  logic                        last_char;

  modport source (output valid, output char_value, output last_char, input ready);
  modport sink   (input valid, input char_value, input last_char, output ready);
endinterface

// Output channel: one packed byte per item.
interface pcbp_out_if;
  logic                        valid;
  logic                        ready;
  logic [pcbp_pkg::BYTE_W-1:0] out_byte;
  logic                        run_end;
  logic                        frame_end;

  modport source (output valid, output out_byte, output run_end, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input frame_end,
                  output ready);
endinterface

### rtl/parity_char_bit_packer.sv
// ---------------------------------------------------------------------------
// Parity character bit packer
// Packs nine-bit characters LSB first into a continuous byte stream.
// ---------------------------------------------------------------------------
// The first byte of a character is registered and offered in the cycle after accept.
// A new character is taken only when the result queue is empty or its last
// byte is leaving, so the one-byte output port and its back-pressure set the pace.
// Reset: synchronous, active low; clears the partial byte and the bit offset
// and empties the two-entry result queue; the queue payload is not reset.
module parity_char_bit_packer (
  input  logic      clk,
  input  logic      rst_n,
  pcbp_in_if.sink   in_ch,
  pcbp_out_if.source out_ch
);
  import pcbp_pkg::*;

  // Packing state.
  logic [BYTE_W-1:0] partial_r, partial_nxt;
  logic [OFF_W-1:0]  offset_r, offset_nxt;

  // Two-entry result queue, slot 0 is the head.
  res_t        q_r [2];
  res_t        q_nxt [2];
  logic [1:0]  count_r, count_nxt;

  logic              push, pop, two_res;
  logic [15:0]       shifted;
  logic [BYTE_W-1:0] first_byte, rest_byte;
  logic [3:0]        rest_sh;
  res_t              res0, res1;

  // Handshake: take an item only when the queue will be empty after this cycle.
  assign out_ch.valid     = (count_r != 2'd0);
  assign pop              = out_ch.valid && out_ch.ready;
  assign in_ch.ready      = (count_r == 2'd0) || ((count_r == 2'd1) && out_ch.ready);
  assign push             = in_ch.valid && in_ch.ready;
  assign out_ch.out_byte  = q_r[0].out_byte;
  assign out_ch.run_end   = q_r[0].run_end;
  assign out_ch.frame_end = q_r[0].frame_end;

  // Split the character over the current partial byte and the next one.
  assign shifted    = {7'd0, in_ch.char_value} << offset_r;
  assign first_byte = partial_r | shifted[BYTE_W-1:0];
  assign rest_sh    = 4'd8 - {1'b0, offset_r};
  assign rest_byte  = 8'({7'd0, in_ch.char_value} >> rest_sh);
  assign two_res    = (offset_r == OFF_WRAP) || in_ch.last_char;

  // Result items for this character.
  always_comb begin
    res0.out_byte  = first_byte;
    res0.run_end   = !two_res;
    res0.frame_end = 1'b0;
    res1.out_byte  = rest_byte;
    res1.run_end   = 1'b1;
    res1.frame_end = in_ch.last_char;
  end

  // Next state of the packer and the queue.
  always_comb begin
    partial_nxt = partial_r;
    offset_nxt  = offset_r;
    q_nxt[0]    = q_r[0];
    q_nxt[1]    = q_r[1];
    count_nxt   = count_r;
    if (push) begin
      // The queue is empty once the head leaves, so both slots load fresh.
      q_nxt[0]  = res0;
      q_nxt[1]  = res1;
      count_nxt = two_res ? 2'd2 : 2'd1;
      if (two_res) begin
        partial_nxt = '0;
        offset_nxt  = '0;
      end else begin
        partial_nxt = rest_byte;
        offset_nxt  = offset_r + 3'd1;
      end
    end else if (pop) begin
      q_nxt[0]  = q_r[1];
      count_nxt = count_r - 2'd1;
    end
  end

  // Control state is reset; queue payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      offset_r  <= '0;
      count_r   <= '0;
    end else begin
      partial_r <= partial_nxt;
      offset_r  <= offset_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

`include "parity_char_bit_packer_assert.svh"

  // The queue never holds more than two items.
  `PCBP_ASSERT_ALWAYS(a_count_max, (!rst_n || count_r != 2'd3), "result queue overflow")

  // Reset leaves the queue empty.
  `PCBP_ASSERT_ALWAYS(a_reset_empty, (!rst_n |=> count_r == 2'd0), "queue not empty after reset")

  // A character that yields two bytes fills both slots.
  `PCBP_ASSERT(a_two_fill, (push && two_res |=> count_r == 2'd2), "two-byte character lost a byte")

  // The head of a full queue is never the end of a run.
  `PCBP_ASSERT(a_head_pair, (count_r == 2'd2 |-> !q_r[0].run_end), "run ended early")

  // The last character of a frame clears the partial byte and the bit offset.
  `PCBP_ASSERT(a_frame_clear, (push && in_ch.last_char |=> offset_r == 3'd0 && partial_r == 8'd0),
               "state not cleared after frame")

endmodule
